// ===== hw/rtl/ptmw_pkg.sv =====
`default_nettype none

package ptmw_pkg;

	// store geometry
	localparam int TABLE_COUNT       = 64;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int WALK_LEVELS       = 4;

	localparam int IDX_W     = $clog2(ENTRIES_PER_TABLE);
	localparam int TBL_W     = $clog2(TABLE_COUNT);
	localparam int CNT_W     = $clog2(TABLE_COUNT + 1);
	localparam int LVL_W     = $clog2(WALK_LEVELS);
	localparam int ADDR_W    = TBL_W + IDX_W;
	localparam int MEM_DEPTH = TABLE_COUNT * ENTRIES_PER_TABLE;

	// field widths
	localparam int ENTRY_W    = 64;
	localparam int PA_W       = 52;
	localparam int VA_W       = 48;
	localparam int TN_W       = 6;
	localparam int STATUS_W   = 2;
	localparam int USED_W     = 7;
	localparam int PAGE_SHIFT = 12;
	localparam int PG_W       = PA_W - PAGE_SHIFT;

	// entry bits
	localparam logic [ENTRY_W-1:0] ENTRY_ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
	localparam logic [ENTRY_W-1:0] ENTRY_P         = 64'h1 << 0;
	localparam logic [ENTRY_W-1:0] ENTRY_RW        = 64'h1 << 1;
	localparam logic [ENTRY_W-1:0] ENTRY_PS        = 64'h1 << 7;
	localparam logic [ENTRY_W-1:0] ENTRY_NX        = 64'h1 << 63;

	localparam logic [PA_W-1:0] TABLE_BASE_RESET = 52'h0_0000_0010_0000;

	// opcodes
	localparam logic OP_MAP  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_TABLE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 2'd2;

	localparam int IN_FIELDS_W = PA_W + VA_W + 3 + TN_W + IDX_W;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((ENTRY_W + USED_W + 7) / 8) * 8;

	// input beat layout, lowest field last
	typedef struct packed {
		logic [IN_DATA_W-IN_FIELDS_W-1:0] pad;
		logic [IDX_W-1:0]                 entry_index;
		logic [TN_W-1:0]                  table_number;
		logic                             no_exec;
		logic                             writable;
		logic                             large_page;
		logic [VA_W-1:0]                  virt_addr;
		logic [PA_W-1:0]                  phys_addr;
	} in_beat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ptmw_ram.sv =====
`default_nettype none

module ptmw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/page_table_map_writer.sv =====
`default_nettype none

// channel   dir  handshake                       contents
// s_axis    in   s_axis_tvalid / s_axis_tready   map or read request beat
// m_axis    out  m_axis_tvalid / m_axis_tready   entry, status, tables used
// cfg       in   cfg_valid / cfg_ready           table_base write
//
// a map walks down from the root, a 2 MiB map stopping a level short of a 4 KiB map, and a read
// fetches one entry; the walk runs one level per cycle through the table memory read port
// after reset a clearing pass writes all 32768 store entries, with
// s_axis_tready low; config writes are taken throughout
// a result waits in the output register; a new beat is taken meanwhile,
// and the walk holds in its final state until the output register is free

module page_table_map_writer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// phys_addr, virt_addr, large_page, writable, no_exec, table_number,
	// entry_index, zero pad
	input  wire logic [ptmw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// opcode
	input  wire logic [0:0]                       s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// read_data, tables_used, zero pad
	output logic      [ptmw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// status
	output logic      [ptmw_pkg::STATUS_W-1:0]    m_axis_tuser,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [ptmw_pkg::PA_W-1:0]        cfg_data
);

	import ptmw_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_START = 7'b0000100,
		S_EVAL  = 7'b0001000,
		S_RDAT  = 7'b0010000,
		S_LEAF  = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q;

	// control
	logic [ADDR_W-1:0] clr_q;
	logic [CNT_W-1:0]  nf_q;
	logic [CNT_W-1:0]  nf_next;
	logic [LVL_W-1:0]  lvl_q;
	logic [PA_W-1:0]   base_q;
	logic              m_tvalid_q;

	// payload
	in_beat_t               item_q;
	logic                   op_q;
	logic [TBL_W-1:0]       cur_q;
	logic [ENTRY_W-1:0]     res_data_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic [OUT_DATA_W-1:0]  m_tdata_q;
	logic [STATUS_W-1:0]    m_tuser_q;
	logic [ADDR_W-1:0]      rd_addr_s1;
	logic                   fwd_s1;
	logic [ENTRY_W-1:0]     fwd_data_s1;

	// memory port
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ENTRY_W:0]  ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ENTRY_W:0]  ram_rdata;

	// walk step
	logic [IDX_W-1:0]   vidx [WALK_LEVELS];
	logic [LVL_W-1:0]   last_lvl;
	logic [TBL_W-1:0]   rd_tbl;
	logic [ENTRY_W-1:0] rd_entry;
	logic [PG_W-1:0]    fresh_hi;
	logic [PG_W-1:0]    off_hi;
	logic               present;
	logic               no_free;
	logic               in_store;
	logic               tn_ok;
	logic [ENTRY_W-1:0] walk_entry;
	logic [ENTRY_W-1:0] leaf_entry;
	logic [TBL_W-1:0]   cur_new;
	logic               alloc;

	// an entry counts as written only if its tag matches its table: tables
	// handed out since reset carry tag one, so allocation acts as a clear
	function automatic logic tag_of(input logic [TBL_W-1:0] k, input logic [CNT_W-1:0] nf);
		return (k != '0) && (CNT_W'(k) < nf);
	endfunction

	ptmw_ram #(
		.WIDTH(ENTRY_W + 1),
		.DEPTH(MEM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		// per-level indexes, root level from the top bits
		for (int lv = 0; lv < WALK_LEVELS; lv++) begin
			vidx[lv] = item_q.virt_addr[PAGE_SHIFT + IDX_W*(WALK_LEVELS-1-lv) +: IDX_W];
		end
		last_lvl = item_q.large_page ? LVL_W'(WALK_LEVELS - 2) : LVL_W'(WALK_LEVELS - 1);

		// read data of last cycle, with same-cycle write forwarded
		rd_tbl = rd_addr_s1[ADDR_W-1:IDX_W];
		if (fwd_s1) begin
			rd_entry = fwd_data_s1;
		end else if (ram_rdata[ENTRY_W] == tag_of(rd_tbl, nf_q)) begin
			rd_entry = ram_rdata[ENTRY_W-1:0];
		end else begin
			rd_entry = '0;
		end

		present  = |(rd_entry & ENTRY_P);
		no_free  = !present && (nf_q >= CNT_W'(TABLE_COUNT));
		fresh_hi = base_q[PA_W-1:PAGE_SHIFT] + PG_W'(nf_q);
		off_hi   = rd_entry[PA_W-1:PAGE_SHIFT] - base_q[PA_W-1:PAGE_SHIFT];
		// a fresh pointer always maps back to the fresh table
		in_store = !present || (off_hi < PG_W'(TABLE_COUNT));
		cur_new  = present ? off_hi[TBL_W-1:0] : nf_q[TBL_W-1:0];

		walk_entry = present ? rd_entry
		                     : (((ENTRY_W'(fresh_hi)) << PAGE_SHIFT) & ENTRY_ADDR_MASK) | ENTRY_P;
		if (item_q.writable) begin
			walk_entry = walk_entry | ENTRY_RW;
		end
		if (!item_q.no_exec) begin
			walk_entry = walk_entry & ~ENTRY_NX;
		end

		leaf_entry = (ENTRY_W'(item_q.phys_addr) & ENTRY_ADDR_MASK) | ENTRY_P;
		if (item_q.large_page) begin
			leaf_entry = leaf_entry | ENTRY_PS;
		end
		if (item_q.writable) begin
			leaf_entry = leaf_entry | ENTRY_RW;
		end
		if (item_q.no_exec) begin
			leaf_entry = leaf_entry | ENTRY_NX;
		end

		alloc   = (state_q == S_EVAL) && !present && !no_free;
		nf_next = nf_q + CNT_W'(alloc);

		tn_ok = 32'(item_q.table_number) < TABLE_COUNT;

		ram_we    = 1'b0;
		ram_waddr = rd_addr_s1;
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_START: begin
				if (op_q == OP_MAP) begin
					ram_raddr = {TBL_W'(0), vidx[0]};
				end else begin
					ram_raddr = {TBL_W'(item_q.table_number), item_q.entry_index};
				end
			end
			S_EVAL: begin
				// entry written back unless no table was free for it
				ram_we    = !no_free;
				ram_wdata = {tag_of(rd_tbl, nf_next), walk_entry};
				ram_raddr = {cur_new, vidx[LVL_W'(lvl_q + 1'b1)]};
			end
			S_LEAF: begin
				ram_we    = 1'b1;
				ram_waddr = {cur_q, vidx[last_lvl]};
				ram_wdata = {tag_of(cur_q, nf_q), leaf_entry};
			end
			S_IDLE, S_RDAT, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			nf_q       <= CNT_W'(1);
			lvl_q      <= '0;
			base_q     <= TABLE_BASE_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				base_q <= cfg_data;
			end
			// output register loads from the final state or drains
			if (state_q == S_FIN && (!m_tvalid_q || m_axis_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			nf_q <= nf_next;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					lvl_q <= '0;
					if (op_q == OP_MAP) begin
						state_q <= S_EVAL;
					end else begin
						state_q <= tn_ok ? S_RDAT : S_FIN;
					end
				end
				S_EVAL: begin
					if (no_free || !in_store) begin
						state_q <= S_FIN;
					end else if (lvl_q == LVL_W'(last_lvl - 1'b1)) begin
						state_q <= S_LEAF;
					end else begin
						lvl_q <= lvl_q + 1'b1;
					end
				end
				S_RDAT, S_LEAF: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!m_tvalid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1  <= ram_raddr;
		fwd_s1      <= ram_we && (ram_waddr == ram_raddr);
		fwd_data_s1 <= ram_wdata[ENTRY_W-1:0];

		if (state_q == S_IDLE && s_axis_tvalid) begin
			item_q <= in_beat_t'(s_axis_tdata);
			op_q   <= s_axis_tuser[0];
		end
		if (state_q == S_START) begin
			res_data_q   <= '0;
			res_status_q <= (op_q == OP_READ && !tn_ok) ? ST_OUTSIDE : ST_DONE;
		end
		if (state_q == S_EVAL) begin
			cur_q <= cur_new;
			if (no_free) begin
				res_status_q <= ST_NO_TABLE;
			end else if (!in_store) begin
				res_status_q <= ST_OUTSIDE;
			end
		end
		if (state_q == S_RDAT) begin
			res_data_q <= rd_entry;
		end
		if (state_q == S_FIN && (!m_tvalid_q || m_axis_tready)) begin
			m_tdata_q <= OUT_DATA_W'({USED_W'(nf_q), res_data_q});
			m_tuser_q <= res_status_q;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;
	assign cfg_ready     = 1'b1;

	// memory is written only by the clearing pass and the walk
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_EVAL || state_q == S_LEAF))
		else $error("store written outside clear or walk");

	// allocator stays within the store, root always counted
	a_nf_range: assert property (@(posedge clk) disable iff (!arst_n)
		(nf_q >= CNT_W'(1)) && (nf_q <= CNT_W'(TABLE_COUNT)))
		else $error("free table counter out of range");

	// at most one table handed out per cycle
	a_nf_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (nf_q == $past(nf_q) || nf_q == CNT_W'($past(nf_q) + 1'b1)))
		else $error("free table counter jumped");

	// the walk never goes past the leaf level
	a_walk_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |-> (lvl_q < last_lvl))
		else $error("walk level beyond leaf");

endmodule

`default_nettype wire
